[rtl/core/ptm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptm_pkg
// Shared constants and types of the per-channel trimmed-mean filter.
// ----------------------------------------------------------------------------
package ptm_pkg;

  localparam int CHANNEL_BITS   = 3;   // ADC channel number
  localparam int SLOT_OUT_BITS  = 2;   // slot field of a result
  localparam int COUNT_BITS     = 4;   // kept_count field, also divisor width
  localparam int CFG_REGS       = 4;   // writable slot channel registers
  localparam int CFG_INDEX_BITS = 3;

  // divider status as seen by the sequencer
  typedef struct packed {
    logic busy;
    logic done;   // quotient valid, held until the next start
  } div_status_t;

endpackage

[rtl/core/per_channel_trimmed_mean.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_channel_trimmed_mean
// Per-slot window of ADC samples; on a full window, drops the two largest and
// two smallest samples and emits the truncated mean of the rest.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): one request carries a sample and its ADC
// channel. The first slot whose channel register matches takes it; a request
// that matches no slot is consumed and dropped. Output channel
// (out_valid/out_ready): slot, average and kept_count of a completed window.
// Config port: cfg_write with cfg_index 0..3 sets a slot's channel; other
// indexes are ignored. Write only while the block is idle.
// A sample that does not complete a window is taken without stalling. One
// that completes a window drops in_ready while the block reads the window
// memory and tracks extremes, removes them from the sum, and runs a
// one-bit-per-cycle divider. The result sits in an output register; the
// next request is taken while it waits. If a second window completes before
// the first result is taken, the block holds in_ready low until the output
// register frees up.
// Reset clears the fill counts, the output valid and the channel registers
// (slot i gets channel 2*i mod 8). The window memory needs no clearing.
// ----------------------------------------------------------------------------
module per_channel_trimmed_mean #(
  parameter int WINDOW      = 10,
  parameter int SLOTS       = 4,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [SAMPLE_BITS-1:0]        sample,
  input  logic [ptm_pkg::CHANNEL_BITS-1:0]     channel,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [ptm_pkg::SLOT_OUT_BITS-1:0]    slot,
  output logic signed [SAMPLE_BITS-1:0]        average,
  output logic [ptm_pkg::COUNT_BITS-1:0]       kept_count,
  input  logic                                 cfg_write,
  input  logic [ptm_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [ptm_pkg::CHANNEL_BITS-1:0]     cfg_data
);

  localparam int CHB      = ptm_pkg::CHANNEL_BITS;
  localparam int CB       = ptm_pkg::COUNT_BITS;
  localparam int DEPTH    = SLOTS * WINDOW;
  localparam int AW       = $clog2(DEPTH);
  localparam int SB       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int IW       = $clog2(WINDOW);
  localparam int JW       = $clog2(WINDOW + 1);
  localparam int SUM_BITS = SAMPLE_BITS + $clog2(WINDOW);
  localparam int EXT      = SUM_BITS - SAMPLE_BITS;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SCAN = 5'b00010,
    S_TRIM = 5'b00100,
    S_DIV  = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t state;

  // channel registers
  logic [CHB-1:0] slot_channel [SLOTS];

  for (genvar i = 0; i < SLOTS; i++) begin : g_chan
    if (i < ptm_pkg::CFG_REGS) begin : g_rw
      always_ff @(posedge clk) begin
        if (rst) begin
          slot_channel[i] <= CHB'(2 * i);
        end else if (cfg_write && cfg_index == ptm_pkg::CFG_INDEX_BITS'(i)) begin
          slot_channel[i] <= cfg_data;
        end
      end
    end else begin : g_ro
      assign slot_channel[i] = CHB'(2 * i);
    end
  end

  // lowest matching slot wins
  logic          hit;
  logic [SB-1:0] hit_slot;

  always_comb begin
    hit      = 1'b0;
    hit_slot = '0;
    for (int s = SLOTS - 1; s >= 0; s--) begin
      if (slot_channel[s] == channel) begin
        hit      = 1'b1;
        hit_slot = SB'(s);
      end
    end
  end

  logic [IW-1:0] fill [SLOTS];
  logic [IW-1:0] hit_fill;
  logic          accept;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready && hit;
  assign hit_fill = fill[hit_slot];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < SLOTS; s++) begin
        fill[s] <= '0;
      end
    end else if (accept) begin
      fill[hit_slot] <= (hit_fill == IW'(WINDOW - 1)) ? '0 : hit_fill + IW'(1);
    end
  end

  // window memory
  logic [AW-1:0]          base;
  logic [AW-1:0]          waddr;
  logic [AW-1:0]          raddr;
  logic [SAMPLE_BITS-1:0] rdata;
  logic [JW-1:0]          j;

  assign waddr = AW'(hit_slot * WINDOW) + AW'(hit_fill);
  assign raddr = base + AW'(j);

  ptm_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (DEPTH)
  ) u_window (
    .clk   (clk),
    .we    (accept),
    .waddr (waddr),
    .wdata (sample),
    .raddr (raddr),
    .rdata (rdata)
  );

  // scan and trim datapath
  logic signed [SAMPLE_BITS-1:0] x;
  logic signed [SAMPLE_BITS-1:0] hi1, hi2, lo1, lo2, tv;
  logic [IW-1:0]                 hi1i, hi2i, lo1i, lo2i, pj;
  logic signed [SUM_BITS-1:0]    sum;
  logic [CB-1:0]                 cnt;
  logic [1:0]                    k;
  logic                          trm;
  logic [SB-1:0]                 cur_slot;
  logic                          div_go;

  assign x  = rdata;
  assign pj = IW'(j - JW'(1));

  always_comb begin
    case (k)
      2'd0: begin
        tv  = hi1;
        trm = 1'b1;
      end
      2'd1: begin
        tv  = hi2;
        trm = (hi2i != hi1i);
      end
      2'd2: begin
        tv  = lo1;
        trm = (lo1i != hi1i) && (lo1i != hi2i);
      end
      2'd3: begin
        tv  = lo2;
        trm = (lo2i != hi1i) && (lo2i != hi2i) && (lo2i != lo1i);
      end
      default: begin
        tv  = hi1;
        trm = 1'b0;
      end
    endcase
  end

  ptm_pkg::div_status_t     div_status;
  logic signed [SAMPLE_BITS-1:0] div_q;

  ptm_div #(
    .WIDTH    (SUM_BITS),
    .OUT_BITS (SAMPLE_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_go),
    .dividend (sum),
    .divisor  (cnt),
    .status   (div_status),
    .quotient (div_q)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      div_go <= 1'b0;
    end else begin
      div_go <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept && hit_fill == IW'(WINDOW - 1)) begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (j == JW'(WINDOW)) begin
            state <= S_TRIM;
          end
        end
        S_TRIM: begin
          if (k == 2'd3) begin
            state  <= S_DIV;
            div_go <= 1'b1;
          end
        end
        S_DIV: begin
          if (!div_go && div_status.done) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE) begin
      j        <= '0;
      k        <= '0;
      base     <= AW'(hit_slot * WINDOW);
      cur_slot <= hit_slot;
    end
    if (state == S_SCAN) begin
      j <= j + JW'(1);
      if (j == JW'(1)) begin
        hi1  <= x;
        hi2  <= x;
        lo1  <= x;
        lo2  <= x;
        hi1i <= '0;
        hi2i <= '0;
        lo1i <= '0;
        lo2i <= '0;
        sum  <= {{EXT{x[SAMPLE_BITS-1]}}, x};
      end else if (j != '0) begin
        sum <= sum + {{EXT{x[SAMPLE_BITS-1]}}, x};
        if (x > hi1) begin
          hi2  <= hi1;
          hi2i <= hi1i;
          hi1  <= x;
          hi1i <= pj;
        end else if (x > hi2 || hi2i == hi1i) begin
          hi2  <= x;
          hi2i <= pj;
        end
        if (x < lo1) begin
          lo2  <= lo1;
          lo2i <= lo1i;
          lo1  <= x;
          lo1i <= pj;
        end else if (x < lo2 || lo2i == lo1i) begin
          lo2  <= x;
          lo2i <= pj;
        end
      end
    end
    if (state == S_TRIM) begin
      k <= k + 2'd1;
      if (trm) begin
        sum <= sum - {{EXT{tv[SAMPLE_BITS-1]}}, tv};
      end
      if (k == 2'd0) begin
        cnt <= CB'(WINDOW - 1);
      end else if (trm) begin
        cnt <= cnt - CB'(1);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (state == S_DONE && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!out_valid || out_ready)) begin
      slot       <= ptm_pkg::SLOT_OUT_BITS'(cur_slot);
      average    <= div_q;
      kept_count <= cnt;
    end
  end

endmodule

[rtl/core/ptm_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptm_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ptm_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 40
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/ptm_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptm_div
// Bit-serial signed divider: signed dividend by small unsigned divisor,
// quotient truncated toward zero. One quotient bit per cycle.
// ----------------------------------------------------------------------------
module ptm_div #(
  parameter int WIDTH    = 28,
  parameter int OUT_BITS = 24
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic signed [WIDTH-1:0]           dividend,
  input  logic [ptm_pkg::COUNT_BITS-1:0]    divisor,
  output ptm_pkg::div_status_t              status,
  output logic signed [OUT_BITS-1:0]        quotient
);

  localparam int CB = ptm_pkg::COUNT_BITS;
  localparam int NW = $clog2(WIDTH + 1);

  logic [WIDTH-1:0] quo;
  logic [CB-1:0]    rem;
  logic [CB-1:0]    dsr;
  logic [NW-1:0]    cnt;
  logic             neg;
  logic             busy;
  logic             done;
  logic [CB:0]      trial;
  logic             qbit;
  logic [WIDTH-1:0] quo_signed;

  assign trial = {rem, quo[WIDTH-1]};
  assign qbit  = (trial >= {1'b0, dsr});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
    end else if (busy) begin
      if (cnt == NW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend[WIDTH-1] ? WIDTH'(-dividend) : WIDTH'(dividend);
      rem <= '0;
      dsr <= divisor;
      neg <= dividend[WIDTH-1];
      cnt <= NW'(WIDTH);
    end else if (busy) begin
      rem <= qbit ? CB'(trial - {1'b0, dsr}) : CB'(trial);
      quo <= {quo[WIDTH-2:0], qbit};
      cnt <= cnt - NW'(1);
    end
  end

  assign quo_signed = neg ? WIDTH'(-quo) : quo;
  assign quotient   = quo_signed[OUT_BITS-1:0];
  assign status     = '{busy: busy, done: done};

endmodule
